// File: sv/spgq_pkg.sv
// Shared types and constants of the sorted priority goal queue.
// Used by the channel interfaces, controller, datapath, top level and checker.
package spgq_pkg;

    localparam int DEF_MAX_ENTRIES = 16;
    localparam int TICK_BITS       = 32;
    localparam int KIND_W          = 4;
    localparam int PRIO_W          = 7;
    localparam int IDX_W           = 4;
    localparam int COUNT_W         = 5;
    localparam int IDLE_W          = 8;

    localparam logic [PRIO_W-1:0] PRIO_CAP   = 7'd100;
    localparam logic [IDLE_W-1:0] IDLE_LIMIT = 8'd3;

    typedef enum logic [2:0] {
        ACT_INSERT = 3'd0,
        ACT_REMOVE = 3'd1,
        ACT_POP    = 3'd2,
        ACT_CLEAR  = 3'd3,
        ACT_QUERY  = 3'd4
    } t_action;

    typedef struct packed {
        t_action               action;
        logic [KIND_W-1:0]     goal_kind;
        logic [PRIO_W-1:0]     priority_req;
        logic [TICK_BITS-1:0]  expiry;
        logic [IDX_W-1:0]      entry_index;
        logic [TICK_BITS-1:0]  now_tick;
        logic [IDLE_W-1:0]     idle_count;
    } t_cmd;

    typedef struct packed {
        logic                  ok;
        logic [COUNT_W-1:0]    entry_count;
        logic                  top_valid;
        logic [KIND_W-1:0]     top_kind;
        logic [PRIO_W-1:0]     top_priority;
        logic [TICK_BITS-1:0]  top_expiry;
        logic                  needs_new;
    } t_res;

    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [PRIO_W-1:0]     prio;
        logic [TICK_BITS-1:0]  expiry;
    } t_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_REPORT
    } t_state;

    typedef struct packed {
        logic cap_in;
        logic exec;
        logic load_out;
    } t_ctrl;

endpackage

// File: sv/spgq_if.sv
// Valid/ready channel interfaces for command and result words.
// Depends on spgq_pkg for the payload types.
interface spgq_in_if import spgq_pkg::*; ();
    logic valid;
    logic ready;
    t_cmd data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface spgq_out_if import spgq_pkg::*; ();
    logic valid;
    logic ready;
    t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/spgq_ctrl.sv
// Controller of the goal queue: capture, update and report sequence,
// and the result valid flag. Depends on spgq_pkg.
module spgq_ctrl import spgq_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_out_ready,
    output logic  o_in_ready,
    output logic  o_out_valid,
    output t_ctrl o_ctrl
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   in_ready;
    t_ctrl  ctrl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state  = r_state;
        ctrl     = '0;
        in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (i_in_valid) begin
                    ctrl.cap_in = 1'b1;
                    n_state     = ST_EXEC;
                end
            end
            ST_EXEC: begin
                ctrl.exec = 1'b1;
                n_state   = ST_REPORT;
            end
            ST_REPORT: begin
                // hold until the result register is free
                if (!r_out_valid || i_out_ready) begin
                    ctrl.load_out = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (ctrl.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;
    assign o_ctrl      = ctrl;

endmodule

// File: sv/spgq_datapath.sv
// Datapath of the goal queue: command register, sorted entry cells,
// held count and result register. Depends on spgq_pkg.
module spgq_datapath import spgq_pkg::*; #(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_ctrl i_ctrl,
    input  t_cmd  i_cmd,
    output t_res  o_res
);

    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

    t_cmd              r_in;
    t_entry            r_cells [MAX_ENTRIES];
    t_entry            n_cells [MAX_ENTRIES];
    logic [CW-1:0]     r_count, n_count;
    logic              r_ok, n_ok;
    t_res              r_res, n_res;

    logic [MAX_ENTRIES-1:0] after;
    t_entry            new_entry;
    logic [CMPW-1:0]   rm_idx;
    logic              rm_en;
    logic              full;

    always_comb begin
        new_entry.kind   = r_in.goal_kind;
        new_entry.prio   = (r_in.priority_req > PRIO_CAP) ? PRIO_CAP : r_in.priority_req;
        new_entry.expiry = r_in.expiry;
        full = (r_count == CW'(MAX_ENTRIES));
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            after[i] = (CW'(i) >= r_count) || (r_in.priority_req > r_cells[i].prio);
        end
    end

    always_comb begin
        n_cells = r_cells;
        n_count = r_count;
        n_ok    = 1'b0;
        rm_en   = 1'b0;
        rm_idx  = '0;
        case (r_in.action)
            ACT_INSERT: begin
                if (!full) begin
                    if (after[0]) begin
                        n_cells[0] = new_entry;
                    end
                    for (int i = 1; i < MAX_ENTRIES; i++) begin
                        if (after[i] && after[i-1]) begin
                            n_cells[i] = r_cells[i-1];
                        end else if (after[i]) begin
                            n_cells[i] = new_entry;
                        end
                    end
                    n_count = r_count + 1'b1;
                    n_ok    = 1'b1;
                end
            end
            ACT_REMOVE: begin
                rm_idx = CMPW'(r_in.entry_index);
                rm_en  = rm_idx < CMPW'(r_count);
            end
            ACT_POP: begin
                rm_en = (r_count != '0);
            end
            ACT_CLEAR: begin
                n_count = '0;
                n_ok    = 1'b1;
            end
            ACT_QUERY: n_ok = 1'b1;
            default:   n_ok = 1'b0;
        endcase

        if (rm_en) begin
            // close up the gap behind the removed entry
            for (int i = 0; i < MAX_ENTRIES - 1; i++) begin
                if (CMPW'(i) >= rm_idx) begin
                    n_cells[i] = r_cells[i+1];
                end
            end
            n_count = r_count - 1'b1;
            n_ok    = 1'b1;
        end
    end

    always_comb begin
        n_res              = '0;
        n_res.ok           = r_ok;
        n_res.entry_count  = COUNT_W'(r_count);
        n_res.top_valid    = (r_count != '0);
        if (n_res.top_valid) begin
            n_res.top_kind     = r_cells[0].kind;
            n_res.top_priority = r_cells[0].prio;
            n_res.top_expiry   = r_cells[0].expiry;
        end
        n_res.needs_new = !n_res.top_valid
                        || ((n_res.top_expiry != '0) && (r_in.now_tick >= n_res.top_expiry))
                        || (r_in.idle_count >= IDLE_LIMIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctrl.exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.cap_in) begin
            r_in <= i_cmd;
        end
        if (i_ctrl.exec) begin
            r_cells <= n_cells;
            r_ok    <= n_ok;
        end
        if (i_ctrl.load_out) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

// File: sv/sorted_priority_goal_queue_top.sv
// Top level of the sorted priority goal queue.
// Depends on spgq_pkg, spgq_if, spgq_ctrl and spgq_datapath.
//
// Usage:
//   i_cmd carries one command word per handshake: insert, remove at index,
//   pop top, clear or query, with the fields each action needs plus the
//   current tick and idle round count. o_res returns exactly one result word
//   per command: ok, entry count, top entry and the needs_new flag.
//   Entries are held in priority order, highest first; equal requests up to
//   100 keep arrival order. Stored priorities are clamped to 100.
// Timing:
//   A command passes through capture, table update and result load. The
//   result is valid on the cycle after the load. A new command is accepted
//   only after the last result load, which can wait on a stall, as set by the
//   controller sequence around the single update of the entry cells.
// Reset:
//   Synchronous, active low. The table is emptied; entry contents are left.
// Stall:
//   A stalled result holds in the output register. The next command is still
//   accepted and updated; its result load waits until the register is taken.
module sorted_priority_goal_queue_top import spgq_pkg::*; #(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    spgq_in_if.sink       i_cmd,
    spgq_out_if.source    o_res
);

    t_ctrl ctrl;
    logic  in_ready;
    logic  out_valid;
    t_res  res;

    spgq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .i_out_ready (o_res.ready),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_ctrl      (ctrl)
    );

    spgq_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .i_cmd   (i_cmd.data),
        .o_res   (res)
    );

    assign i_cmd.ready = in_ready;
    assign o_res.valid = out_valid;
    assign o_res.data  = res;

endmodule

// File: sv/spgq_checker.sv
// Port-level checks of the goal queue, bound to the top level.
// Depends on spgq_pkg and sorted_priority_goal_queue_top.
module spgq_checker import spgq_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input t_res i_res
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_res))
        else $error("stalled result word dropped or changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready ##1 !i_in_ready)
        else $error("command accepted during update");

    a_empty_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_res.top_valid |->
            i_res.needs_new && (i_res.top_kind == '0) && (i_res.entry_count == '0))
        else $error("empty table reported inconsistently");

endmodule

bind sorted_priority_goal_queue_top spgq_checker u_spgq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cmd.valid),
    .i_in_ready  (i_cmd.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_res       (o_res.data)
);
